### sv/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Each macro expands to one labeled concurrent assertion clocked on clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/bnt_pkg.sv
`timescale 1ns / 1ps
// Package for the brace nesting tracker: byte codes, scan state type,
// indicator codes and the per-byte judging function. No dependencies.
package bnt_pkg;

   // Default width of the running nesting level.
   localparam int LEVEL_BITS_DEF = 16;

   // Byte codes the scanner reacts to.
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_SHARP  = 8'h23;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // Line delta saturation bound.
   localparam logic signed [8:0] DELTA_MAX = 9'sd255;

   // Direction indicator codes.
   typedef logic [1:0] ind_type;
   localparam ind_type IND_NONE     = 2'd0;
   localparam ind_type IND_CLOSE    = 2'd1;
   localparam ind_type IND_BALANCED = 2'd2;
   localparam ind_type IND_OPEN     = 2'd3;

   // Mode flags and per-line counters of the scanner.
   typedef struct packed {
      logic              blk;
      logic              dq;
      logic              sq;
      logic              hash;
      logic              blank;
      logic              seen;
      logic signed [8:0] delta;
   } scan_state_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // A quote counts unless it is escaped by a single backslash.
   function automatic logic quote_counts(input logic [7:0] p1, input logic [7:0] p2);
      return (p1 != CH_BSLASH) || (p2 == CH_BSLASH);
   endfunction

   // Judge byte c with lookahead n (n_ok low when there is none) and the two
   // previous bytes of the line p1, p2.
   function automatic scan_state_type scan_judge(input scan_state_type st,
                                                 input logic [7:0] c,
                                                 input logic n_ok,
                                                 input logic [7:0] n,
                                                 input logic [7:0] p1,
                                                 input logic [7:0] p2);
      scan_state_type r;
      logic n_star;
      logic n_slash;
      logic n_brace;
      logic q_ok;
      r       = st;
      n_star  = n_ok && (n == CH_STAR);
      n_slash = n_ok && (n == CH_SLASH);
      n_brace = n_ok && ((n == CH_LBRACE) || (n == CH_RBRACE));
      q_ok    = quote_counts(p1, p2);
      if (!st.blk && !st.hash && !st.dq && !st.sq) begin
         if ((c == CH_SLASH) && n_star) begin
            r.blk   = 1'b1;
            r.blank = 1'b0;
         end else if (st.blank && ((c == CH_SHARP) || (c == CH_COLON)) && !n_brace) begin
            r.hash  = 1'b1;
            r.blank = 1'b0;
         end else if ((c == CH_DQUOTE) && q_ok) begin
            r.dq    = 1'b1;
            r.blank = 1'b0;
         end else if ((c == CH_SQUOTE) && q_ok) begin
            r.sq    = 1'b1;
            r.blank = 1'b0;
         end else if (c == CH_LBRACE) begin
            if (st.delta < DELTA_MAX) begin
               r.delta = st.delta + 9'sd1;
            end
            r.seen  = 1'b1;
            r.blank = 1'b0;
         end else if (c == CH_RBRACE) begin
            if (st.delta > -DELTA_MAX) begin
               r.delta = st.delta - 9'sd1;
            end
            r.seen  = 1'b1;
            r.blank = 1'b0;
         end else if (!is_blank(c)) begin
            r.blank = 1'b0;
         end
      end else if (st.blk && (c == CH_STAR) && n_slash) begin
         r.blk = 1'b0;
      end else if (st.dq && (c == CH_DQUOTE) && q_ok) begin
         r.dq = 1'b0;
      end else if (st.sq && (c == CH_SQUOTE) && q_ok) begin
         r.sq = 1'b0;
      end
      return r;
   endfunction

endpackage

### sv/brace_nesting_tracker_core.sv
`timescale 1ns / 1ps
// A line's result is registered in the line record stage, then in the result stage.
// Throughput: one byte per cycle unless req_stall is high; each byte is judged
// when its successor arrives, and the last byte of a line is judged with it.
// The level adder in the second stage handles one line per cycle unless stalled.
// Synchronous reset clears all scan state, the level and both stage valid flags.
// Top level of the brace nesting tracker; depends on bnt_pkg.
module brace_nesting_tracker_core
   import bnt_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_char_code,
   input  logic                req_line_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_brace_seen,
   output logic signed [8:0]   rsp_line_delta,
   output logic signed [15:0]  rsp_nest_level,
   output ind_type             rsp_indicator,
   output logic signed [15:0]  rsp_shown_level
);

   localparam int SUM_W = ((LEVEL_BITS > 9) ? LEVEL_BITS : 9) + 1;

   // Scan state carried from beat to beat.
   scan_state_type st_ff, st_in;
   logic [7:0]     pend_ff, pend_in;
   logic           pend_valid_ff, pend_valid_in;
   logic [7:0]     back1_ff, back1_in;
   logic [7:0]     back2_ff, back2_in;

   // Line record stage and result stage.
   logic                     mid_valid_ff;
   logic                     mid_seen_ff;
   logic signed [8:0]        mid_delta_ff;
   logic signed [LEVEL_BITS-1:0] level_ff, level_in;
   logic                     out_valid_ff;
   logic                     out_seen_ff;
   logic signed [8:0]        out_delta_ff;
   logic signed [15:0]       out_nest_ff, out_nest_in;
   ind_type                  out_ind_ff, out_ind_in;
   logic signed [15:0]       out_shown_ff, out_shown_in;

   logic           out_ready;
   logic           mid_ready;
   logic           req_take;
   logic           mid_move;
   scan_state_type st_one;
   scan_state_type st_two;
   logic [7:0]     b1_mid;
   logic [7:0]     b2_mid;

   // Stall chain: the result register frees the line stage, which frees input.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign mid_ready = !mid_valid_ff || out_ready;
   assign req_stall = !mid_ready;
   assign req_take  = req_valid && mid_ready;
   assign mid_move  = mid_valid_ff && out_ready;

   // Judge the pending byte with this beat as lookahead, then on a line end
   // judge this beat with no lookahead.
   always_comb begin
      st_one = st_ff;
      b1_mid = back1_ff;
      b2_mid = back2_ff;
      if (pend_valid_ff) begin
         st_one = scan_judge(st_ff, pend_ff, 1'b1, req_char_code, back1_ff, back2_ff);
         b1_mid = pend_ff;
         b2_mid = back1_ff;
      end
      st_two = scan_judge(st_one, req_char_code, 1'b0, 8'h00, b1_mid, b2_mid);
   end

   // Next scan state.
   always_comb begin
      st_in         = st_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      back1_in      = back1_ff;
      back2_in      = back2_ff;
      if (req_take) begin
         if (!req_line_end) begin
            st_in         = st_one;
            pend_in       = req_char_code;
            pend_valid_in = 1'b1;
            back1_in      = b1_mid;
            back2_in      = b2_mid;
         end else begin
            // Quote and block comment modes carry over; the rest restarts.
            st_in         = st_two;
            st_in.hash    = 1'b0;
            st_in.blank   = 1'b1;
            st_in.seen    = 1'b0;
            st_in.delta   = '0;
            pend_in       = '0;
            pend_valid_in = 1'b0;
            back1_in      = '0;
            back2_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= '{blk: 1'b0, dq: 1'b0, sq: 1'b0, hash: 1'b0,
                            blank: 1'b1, seen: 1'b0, delta: '0};
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
         back1_ff      <= '0;
         back2_ff      <= '0;
      end else begin
         st_ff         <= st_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         back1_ff      <= back1_in;
         back2_ff      <= back2_in;
      end
   end

   // Line record register: written when a line's last beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (mid_ready) begin
         mid_valid_ff <= req_take && req_line_end;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_line_end) begin
         mid_seen_ff  <= st_two.seen;
         mid_delta_ff <= st_two.delta;
      end
   end

   // Running level with saturation, and the displayed level.
   logic signed [SUM_W-1:0] lvl_sum;
   logic signed [SUM_W-1:0] lvl_hi;
   logic signed [SUM_W-1:0] lvl_lo;
   logic signed [31:0]      lvl_ext;

   always_comb begin
      lvl_hi  = SUM_W'({1'b0, {(LEVEL_BITS-1){1'b1}}});
      lvl_lo  = {{(SUM_W-LEVEL_BITS+1){1'b1}}, {(LEVEL_BITS-1){1'b0}}};
      lvl_sum = SUM_W'(level_ff) + SUM_W'(mid_delta_ff);
      if (lvl_sum > lvl_hi) begin
         level_in = lvl_hi[LEVEL_BITS-1:0];
      end else if (lvl_sum < lvl_lo) begin
         level_in = lvl_lo[LEVEL_BITS-1:0];
      end else begin
         level_in = lvl_sum[LEVEL_BITS-1:0];
      end
      lvl_ext     = 32'(level_in);
      out_nest_in = lvl_ext[15:0];
      // A negative delta leaves room below the upper limit, so no clamp here.
      if (mid_delta_ff < 9'sd0) begin
         out_shown_in = 16'(lvl_ext + 32'sd1);
      end else begin
         out_shown_in = lvl_ext[15:0];
      end
      if (!mid_seen_ff) begin
         out_ind_in = IND_NONE;
      end else if (mid_delta_ff < 9'sd0) begin
         out_ind_in = IND_CLOSE;
      end else if (mid_delta_ff == 9'sd0) begin
         out_ind_in = IND_BALANCED;
      end else begin
         out_ind_in = IND_OPEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (mid_move) begin
            level_ff <= level_in;
         end
         if (out_ready) begin
            out_valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mid_move) begin
         out_seen_ff  <= mid_seen_ff;
         out_delta_ff <= mid_delta_ff;
         out_nest_ff  <= out_nest_in;
         out_ind_ff   <= out_ind_in;
         out_shown_ff <= out_shown_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_brace_seen  = out_seen_ff;
   assign rsp_line_delta  = out_delta_ff;
   assign rsp_nest_level  = out_nest_ff;
   assign rsp_indicator   = out_ind_ff;
   assign rsp_shown_level = out_shown_ff;

endmodule

### sv/bnt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the brace nesting tracker, bound to the top level.
// Depends on bnt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bnt_checker
   import bnt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_char_code,
   input logic               req_line_end,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_brace_seen,
   input logic signed [8:0]  rsp_line_delta,
   input logic signed [15:0] rsp_nest_level,
   input ind_type            rsp_indicator,
   input logic signed [15:0] rsp_shown_level
);

   // A stalled result beat stays put.
   `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_nest_level) && $stable(rsp_line_delta), "result beat changed while stalled")

   // A line without braces reports nothing and shows the plain level.
   `ASSERT_CLK(a_no_brace, rsp_valid && !rsp_brace_seen |-> rsp_line_delta == 9'sd0 && rsp_indicator == IND_NONE && rsp_shown_level == rsp_nest_level, "line without braces reports activity")

   // A net closing line shows one level above the new level.
   `ASSERT_CLK(a_closing, rsp_valid && rsp_brace_seen && rsp_line_delta < 9'sd0 |-> rsp_indicator == IND_CLOSE && rsp_shown_level == 16'(rsp_nest_level + 16'sd1), "closing line mismatch")

   // An opening or balanced line shows the new level itself.
   `ASSERT_CLK(a_opening, rsp_valid && rsp_brace_seen && rsp_line_delta >= 9'sd0 |-> (rsp_indicator == IND_OPEN || rsp_indicator == IND_BALANCED) && rsp_shown_level == rsp_nest_level, "opening line mismatch")

   // No result right after reset.
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind brace_nesting_tracker_core bnt_checker u_bnt_checker (.*);
